// ----- src/ktfc_pkg.sv -----
package ktfc_pkg;

	localparam int unsigned ROUND_COUNT   = 32;
	localparam logic [7:0]  DECRYPT_START = 8'd248;
	localparam logic [7:0]  OFFSET_STEP   = 8'd8;

	localparam logic OP_KEY   = 1'b0;
	localparam logic OP_BLOCK = 1'b1;

	localparam logic [1:0] REG_KEY_LEN      = 2'd0;
	localparam logic [1:0] REG_DECRYPT_MODE = 2'd1;

	typedef struct packed {
		logic        op;
		logic [7:0]  key_index;
		logic [7:0]  key_byte;
		logic [63:0] block_lo;
		logic [63:0] block_hi;
	} in_t;

	typedef struct packed {
		logic [63:0] result_lo;
		logic [63:0] result_hi;
		logic        keyed;
	} out_t;

	function automatic logic [7:0] mix_box(input logic [3:0] idx);
		logic [7:0] v;
		unique case (idx)
			4'd0:  v = 8'h0F;
			4'd1:  v = 8'h4B;
			4'd2:  v = 8'h87;
			4'd3:  v = 8'hC3;
			4'd4:  v = 8'h1E;
			4'd5:  v = 8'h5A;
			4'd6:  v = 8'h96;
			4'd7:  v = 8'hD2;
			4'd8:  v = 8'h2D;
			4'd9:  v = 8'h69;
			4'd10: v = 8'hA5;
			4'd11: v = 8'hE1;
			4'd12: v = 8'h3C;
			4'd13: v = 8'h78;
			4'd14: v = 8'hB4;
			default: v = 8'hF0;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ----- src/keyed_table_feistel_cipher_128.sv -----
// Keyed-table Feistel cipher, 128-bit block. One item at a time: in_ready is high only
// while the sequencer is idle. A key byte write at the last key index (length register
// minus one) also runs the key schedule: table fill, a swap pass, then the key XOR and
// whitening fold. A data block runs 32 rounds; each half-round is 7 steps of 32-bit
// adds, a round-key read and an S-byte read of the table, which is a single-read-port
// memory of four byte banks. Before the first schedule the table and whitening words
// read as zero and keyed is 0. A result waits in an output register while the next
// item is taken.
module keyed_table_feistel_cipher_128 (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  ktfc_pkg::in_t        in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ktfc_pkg::out_t       out_data,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_INIT, ST_SW_RD, ST_SW_ACC, ST_SW_WJ, ST_SW_WI, ST_XR_RD, ST_XR_WR,
		ST_RND_BEGIN, ST_H_KEY, ST_H_T, ST_H_B, ST_H_C, ST_H_D, ST_H_S, ST_H_W,
		ST_RND_END, ST_FIN
	} state_t;

	state_t state_q;

	logic [8:0]  key_len_q;
	logic        decrypt_q;
	logic        key_done_q;
	logic        tbl_live_q;
	logic [3:0][31:0] white_q;
	logic [3:0][31:0] w_q;
	logic [7:0]  offset_q;
	logic [4:0]  rnd_q;
	logic        half_q;
	logic        is_blk_q;
	logic [7:0]  i_q;
	logic [7:0]  kidx_q;
	logic [7:0]  acc_q;
	logic [7:0]  pi_q;
	logic [1:0]  sel_q;
	logic [31:0] rk_q, t_q, a_q, b_q, c_q, d_q, sum_q, f_q;
	logic        out_valid_q;
	ktfc_pkg::out_t out_q;

	// table memory: four byte banks, one row read and one byte written per cycle
	logic        perm_we;
	logic [7:0]  perm_wa;
	logic [7:0]  perm_wd;
	logic [5:0]  perm_ra;
	logic [31:0] rdw_q;
	logic [7:0]  bank_mem [4][64];
	logic [7:0]  key_ra;
	logic [7:0]  krd_q;
	logic [7:0]  key_mem [256];

	logic        cfg_wr;
	logic        in_xfer;
	logic        slot_free;
	logic [7:0]  rd_byte;
	logic [7:0]  acc_n;
	logic [31:0] rk_t;
	logic [31:0] d_n;
	logic [7:0]  s_idx;
	logic [7:0]  kidx_n;
	logic [7:0]  xr_byte;

	always_ff @(posedge clk) begin
		if (perm_we) begin
			bank_mem[perm_wa[1:0]][perm_wa[7:2]] <= perm_wd;
		end
		rdw_q <= tbl_live_q ? {bank_mem[3][perm_ra], bank_mem[2][perm_ra],
		                       bank_mem[1][perm_ra], bank_mem[0][perm_ra]} : 32'd0;
	end

	always_ff @(posedge clk) begin
		if (in_xfer && in_data.op == ktfc_pkg::OP_KEY) begin
			key_mem[in_data.key_index] <= in_data.key_byte;
		end
		krd_q <= key_mem[key_ra];
	end

	assign cfg_wr    = psel && penable && pwrite;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == ktfc_pkg::REG_DECRYPT_MODE[0]) ? {31'd0, decrypt_q}
	                                                            : {23'd0, key_len_q};
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign slot_free = !out_valid_q || out_ready;

	assign rd_byte = rdw_q[{sel_q, 3'b000} +: 8];
	assign rk_t    = rk_q;
	assign kidx_n  = ({1'b0, kidx_q} == key_len_q - 9'd1) ? 8'd0 : kidx_q + 8'd1;
	assign acc_n   = krd_q + rd_byte + key_len_q[7:0] +
	                 ktfc_pkg::mix_box(acc_q[3:0]) + acc_q;
	assign d_n     = c_q + (rk_t ^ ktfc_pkg::ror32(t_q, 7));
	assign s_idx   = a_q[31:24] ^ c_q[31:24] ^ b_q[7:0] ^ d_n[7:0];
	assign xr_byte = rd_byte ^ krd_q;

	always_comb begin
		perm_we = 1'b0;
		perm_wa = i_q;
		perm_wd = i_q;
		perm_ra = i_q[7:2];
		key_ra  = kidx_q;
		unique case (state_q)
			ST_INIT:   perm_we = 1'b1;
			ST_SW_ACC: perm_ra = acc_n[7:2];
			ST_SW_WJ: begin
				perm_we = 1'b1;
				perm_wd = rd_byte;
			end
			ST_SW_WI: begin
				perm_we = 1'b1;
				perm_wa = acc_q;
				perm_wd = pi_q;
			end
			ST_XR_WR: begin
				perm_we = 1'b1;
				perm_wd = xr_byte;
			end
			ST_H_KEY:  perm_ra = offset_q[7:2] + {5'd0, half_q};
			ST_H_D:    perm_ra = s_idx[7:2];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			key_len_q    <= 9'd16;
			decrypt_q    <= 1'b0;
			key_done_q   <= 1'b0;
			tbl_live_q   <= 1'b0;
			white_q      <= '0;
			w_q          <= '0;
			offset_q     <= 8'd0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			rnd_q        <= '0;
			half_q       <= 1'b0;
			i_q          <= '0;
			kidx_q       <= '0;
			acc_q        <= '0;
			pi_q         <= '0;
			sel_q        <= '0;
			rk_q         <= '0;
			t_q          <= '0;
			a_q          <= '0;
			b_q          <= '0;
			c_q          <= '0;
			d_q          <= '0;
			sum_q        <= '0;
			f_q          <= '0;
			is_blk_q     <= 1'b0;
		end else begin
			if (state_q == ST_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				if (paddr[2] == ktfc_pkg::REG_KEY_LEN[0]) begin
					key_len_q <= pwdata[8:0];
				end else begin
					decrypt_q <= pwdata[0];
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						is_blk_q <= in_data.op;
						if (in_data.op == ktfc_pkg::OP_BLOCK) begin
							w_q[0]   <= in_data.block_lo[31:0] ^ white_q[0];
							w_q[1]   <= in_data.block_lo[63:32] ^ white_q[1];
							w_q[2]   <= in_data.block_hi[31:0] ^ white_q[2];
							w_q[3]   <= in_data.block_hi[63:32] ^ white_q[3];
							offset_q <= decrypt_q ? ktfc_pkg::DECRYPT_START : 8'd0;
							rnd_q    <= '0;
							half_q   <= 1'b0;
							state_q  <= ST_RND_BEGIN;
						end else if ({1'b0, in_data.key_index} == key_len_q - 9'd1) begin
							tbl_live_q <= 1'b1;
							white_q    <= '0;
							i_q        <= '0;
							state_q    <= ST_INIT;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_INIT: begin
					i_q <= i_q + 8'd1;
					if (i_q == 8'hFF) begin
						kidx_q  <= '0;
						acc_q   <= '0;
						state_q <= ST_SW_RD;
					end
				end
				ST_SW_RD: begin
					sel_q   <= i_q[1:0];
					state_q <= ST_SW_ACC;
				end
				ST_SW_ACC: begin
					acc_q   <= acc_n;
					pi_q    <= rd_byte;
					sel_q   <= acc_n[1:0];
					kidx_q  <= kidx_n;
					state_q <= ST_SW_WJ;
				end
				ST_SW_WJ: state_q <= ST_SW_WI;
				ST_SW_WI: begin
					i_q <= i_q + 8'd1;
					if (i_q == 8'hFF) begin
						kidx_q  <= '0;
						state_q <= ST_XR_RD;
					end else begin
						state_q <= ST_SW_RD;
					end
				end
				ST_XR_RD: begin
					sel_q   <= i_q[1:0];
					state_q <= ST_XR_WR;
				end
				ST_XR_WR: begin
					// fold the final table byte into its whitening word
					white_q[i_q[3:2]][{i_q[1:0], 3'b000} +: 8] <=
						white_q[i_q[3:2]][{i_q[1:0], 3'b000} +: 8] ^ xr_byte;
					kidx_q <= kidx_n;
					i_q    <= i_q + 8'd1;
					if (i_q == 8'hFF) begin
						key_done_q <= 1'b1;
						state_q    <= ST_FIN;
					end else begin
						state_q <= ST_XR_RD;
					end
				end
				ST_RND_BEGIN: begin
					if (decrypt_q) begin
						w_q <= {w_q[0], w_q[3], w_q[2], w_q[1]};
					end
					state_q <= ST_H_KEY;
				end
				ST_H_KEY: state_q <= ST_H_T;
				ST_H_T: begin
					rk_q    <= rdw_q;
					t_q     <= (half_q ? w_q[2] : w_q[0]) +
					           {24'd0, ktfc_pkg::mix_box(rdw_q[27:24])};
					state_q <= ST_H_B;
				end
				ST_H_B: begin
					a_q     <= rk_t ^ ktfc_pkg::ror32(t_q, 1);
					b_q     <= (rk_t ^ ktfc_pkg::ror32(t_q, 1)) +
					           (rk_t ^ ktfc_pkg::ror32(t_q, 2));
					state_q <= ST_H_C;
				end
				ST_H_C: begin
					c_q     <= b_q + (rk_t ^ ktfc_pkg::ror32(t_q, 6));
					sum_q   <= a_q + b_q;
					state_q <= ST_H_D;
				end
				ST_H_D: begin
					d_q     <= d_n;
					sum_q   <= sum_q + c_q;
					sel_q   <= s_idx[1:0];
					state_q <= ST_H_S;
				end
				ST_H_S: begin
					f_q     <= sum_q + d_q + {24'd0, rd_byte};
					state_q <= ST_H_W;
				end
				ST_H_W: begin
					if (half_q) begin
						w_q[3]  <= decrypt_q ? w_q[3] - f_q : w_q[3] + f_q;
						half_q  <= 1'b0;
						state_q <= ST_RND_END;
					end else begin
						w_q[1]  <= decrypt_q ? w_q[1] - f_q : w_q[1] + f_q;
						half_q  <= 1'b1;
						state_q <= ST_H_KEY;
					end
				end
				ST_RND_END: begin
					if (!decrypt_q) begin
						w_q <= {w_q[2], w_q[1], w_q[0], w_q[3]};
						offset_q <= offset_q + ktfc_pkg::OFFSET_STEP;
					end else begin
						offset_q <= offset_q - ktfc_pkg::OFFSET_STEP;
					end
					rnd_q <= rnd_q + 5'd1;
					if (rnd_q == 5'(ktfc_pkg::ROUND_COUNT - 1)) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_RND_BEGIN;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (slot_free) begin
						out_q.keyed <= key_done_q;
						if (is_blk_q) begin
							out_q.result_lo <= {w_q[1] ^ white_q[1], w_q[0] ^ white_q[0]};
							out_q.result_hi <= {w_q[3] ^ white_q[3], w_q[2] ^ white_q[2]};
						end else begin
							out_q.result_lo <= '0;
							out_q.result_hi <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
